FILE: sv/cpod_pkg.sv
// package for the circle pair overlap detector
// shared word types, entity record, state enum and default sizes; no dependencies
package cpod_pkg;

    // default store capacity
    localparam int MAX_ENTITIES_DEF = 32;

    // most pairs reported for one entity word
    localparam int MAX_RESULTS = 31;

    // index of the last drain step after the sweep (three compare stages)
    localparam logic [1:0] DRAIN_LAST = 2'd2;

    // op codes of an input word
    localparam logic OP_ENTITY = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    // input word
    typedef struct packed {
        logic               op;
        logic [15:0]        entity_id;
        logic               alive;
        logic               is_enemy;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [15:0]        radius;
    } ent_word_t;

    // output word
    typedef struct packed {
        logic [15:0] first_id;
        logic [15:0] second_id;
        logic        last;
        logic        overflow;
    } pair_word_t;

    // one stored entity
    typedef struct packed {
        logic [15:0]        id;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [15:0]        r;
        logic               enemy;
    } entity_t;

    // candidate pushed into the compare pipeline
    typedef struct packed {
        logic    valid;
        entity_t ent;
    } cand_t;

    // compare result
    typedef struct packed {
        logic        valid;
        logic [15:0] id;
    } hit_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DRAIN,
        ST_FLUSH
    } state_t;

endpackage

FILE: sv/cpod_cell.sv
// one storage cell of the entity ring
// depends on cpod_pkg for the entity record
module cpod_cell (
    input  logic              clk,
    input  logic              shift,
    input  logic              sel_new,
    input  cpod_pkg::entity_t nbr,
    input  cpod_pkg::entity_t fresh,
    output cpod_pkg::entity_t q
);
    import cpod_pkg::*;

    entity_t ent_reg;
    entity_t ent_next;

    // take the neighbor's entity or a freshly inserted one
    always_comb
    begin
        ent_next = sel_new ? fresh : nbr;
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            ent_reg <= ent_next;
        end
    end

    assign q = ent_reg;

endmodule

FILE: sv/cpod_ring.sv
// rotating ring of entity cells; entry k sits at the head on sweep step k
// depends on cpod_pkg and cpod_cell
module cpod_ring #(
    parameter int N = cpod_pkg::MAX_ENTITIES_DEF
) (
    input  logic              clk,
    input  logic              shift,
    input  logic              ins,
    input  cpod_pkg::entity_t fresh,
    output cpod_pkg::entity_t head
);
    import cpod_pkg::*;

    entity_t cell_q [N];

    // cell i takes from cell i+1; the tail takes the head back or a new entity
    for (genvar i = 0; i < N; i++)
    begin : g_cell
        if (i == N - 1)
        begin : g_tail
            cpod_cell u_cell (
                .clk     (clk),
                .shift   (shift),
                .sel_new (ins),
                .nbr     (cell_q[0]),
                .fresh   (fresh),
                .q       (cell_q[i])
            );
        end
        else
        begin : g_body
            cpod_cell u_cell (
                .clk     (clk),
                .shift   (shift),
                .sel_new (1'b0),
                .nbr     (cell_q[i+1]),
                .fresh   (fresh),
                .q       (cell_q[i])
            );
        end
    end

    assign head = cell_q[0];

endmodule

FILE: sv/cpod_cmp.sv
// three stage circle overlap test: differences, squares, compare
// depends on cpod_pkg for candidate and hit records
module cpod_cmp (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  cpod_pkg::cand_t   cand,
    input  cpod_pkg::entity_t probe,
    output cpod_pkg::hit_t    hit
);
    import cpod_pkg::*;

    // stage 1: differences and radius sum
    logic               v1_reg;
    logic [15:0]        id1_reg;
    logic signed [16:0] dx_reg, dx_next;
    logic signed [16:0] dy_reg, dy_next;
    logic [16:0]        rs_reg, rs_next;

    // stage 2: squares
    logic               v2_reg;
    logic [15:0]        id2_reg;
    logic signed [33:0] dx_prod, dy_prod;
    logic [33:0]        rs_prod;
    logic [31:0]        sqx_reg, sqx_next;
    logic [31:0]        sqy_reg, sqy_next;
    logic [33:0]        rs2_reg;

    // stage 3: compare
    logic               v3_reg, v3_next;
    logic [15:0]        id3_reg;
    logic [32:0]        d2;

    always_comb
    begin
        dx_next = {cand.ent.x[15], cand.ent.x} - {probe.x[15], probe.x};
        dy_next = {cand.ent.y[15], cand.ent.y} - {probe.y[15], probe.y};
        rs_next = {1'b0, cand.ent.r} + {1'b0, probe.r};
    end

    // squares of values below 2^16 in magnitude fit in 32 bits
    always_comb
    begin
        dx_prod  = dx_reg * dx_reg;
        dy_prod  = dy_reg * dy_reg;
        rs_prod  = rs_reg * rs_reg;
        sqx_next = dx_prod[31:0];
        sqy_next = dy_prod[31:0];
    end

    // strict overlap: squared distance below squared radius sum
    always_comb
    begin
        d2      = {1'b0, sqx_reg} + {1'b0, sqy_reg};
        v3_next = v2_reg && ({1'b0, d2} < rs2_reg);
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= cand.valid;
            v2_reg <= v1_reg;
            v3_reg <= v3_next;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            id1_reg <= cand.ent.id;
            dx_reg  <= dx_next;
            dy_reg  <= dy_next;
            rs_reg  <= rs_next;
            id2_reg <= id1_reg;
            sqx_reg <= sqx_next;
            sqy_reg <= sqy_next;
            rs2_reg <= rs_prod;
            id3_reg <= id2_reg;
        end
    end

    assign hit.valid = v3_reg;
    assign hit.id    = id3_reg;

endmodule

FILE: sv/circle_pair_overlap_detector_unit.sv
// circle pair overlap detector: a live entity sweeps the ring of stored entities
// a live entity is followed by a sweep of the ring, a drain of the compare stages and a
// flush, each held while the output is stalled; clear and dead entities leave the unit idle
// a new entity word is taken only while idle, after the flush of the last live entity
// reset clears the entity count, overflow flag and control; stored entries stay undefined
module circle_pair_overlap_detector_unit #(
    parameter int MAX_ENTITIES = cpod_pkg::MAX_ENTITIES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 ent_valid,
    output logic                 ent_ready,
    input  cpod_pkg::ent_word_t  ent_word,
    output logic                 pair_valid,
    input  logic                 pair_ready,
    output cpod_pkg::pair_word_t pair_word
);
    import cpod_pkg::*;

    localparam int IDX_W = $clog2(MAX_ENTITIES);
    localparam int CNT_W = IDX_W + 1;
    localparam int HIT_W = $clog2(MAX_RESULTS + 1);

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   step_reg, step_next;
    logic [1:0]         drain_reg, drain_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   lim_reg;
    logic               store_reg;
    logic               ovf_reg, ovf_next;
    logic [HIT_W-1:0]   hits_reg, hits_next;
    entity_t            probe_reg;
    logic               pend_valid_reg, pend_valid_next;
    logic [15:0]        pend_id_reg, pend_id_next;
    logic               out_valid_reg, out_valid_next;
    pair_word_t         out_word_reg, out_word_next;

    logic               adv;
    logic               accept;
    logic               accept_live;
    logic               full;
    logic               ring_shift;
    logic               flush_go;
    logic               ins;
    entity_t            head;
    entity_t            fresh;
    cand_t              cand;
    hit_t               hit;

    // everything moves unless a word waits at the output unaccepted
    assign adv         = !(out_valid_reg && !pair_ready);
    assign accept      = ent_valid && ent_ready;
    assign accept_live = accept && (ent_word.op == OP_ENTITY) && ent_word.alive;
    assign full        = (count_reg == CNT_W'(MAX_ENTITIES));

    // incoming entity as a record
    always_comb
    begin
        fresh.id    = ent_word.entity_id;
        fresh.x     = ent_word.pos_x;
        fresh.y     = ent_word.pos_y;
        fresh.r     = ent_word.radius;
        fresh.enemy = ent_word.is_enemy;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept_live)
                begin
                    state_next = ST_SWEEP;
                end
            end
            ST_SWEEP:
            begin
                if (adv && step_reg == IDX_W'(MAX_ENTITIES - 1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (adv && drain_reg == DRAIN_LAST)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (adv)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        ent_ready  = 1'b0;
        ring_shift = 1'b0;
        flush_go   = 1'b0;
        unique case (state_reg)
            ST_IDLE:  ent_ready  = 1'b1;
            ST_SWEEP: ring_shift = adv;
            ST_DRAIN: ;
            ST_FLUSH: flush_go   = 1'b1;
            default:  ;
        endcase
    end

    // head candidate: stored entry with at least one enemy in the pair
    always_comb
    begin
        cand.ent   = head;
        cand.valid = (state_reg == ST_SWEEP) && ({1'b0, step_reg} < lim_reg)
                     && (probe_reg.enemy || head.enemy);
        ins        = store_reg && ({1'b0, step_reg} == lim_reg);
    end

    // step, drain and store bookkeeping
    always_comb
    begin
        step_next  = step_reg;
        drain_next = drain_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (accept_live)
        begin
            step_next  = '0;
            drain_next = '0;
            if (full)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + 1'b1;
            end
        end
        else if (accept && ent_word.op == OP_CLEAR)
        begin
            count_next = '0;
            ovf_next   = 1'b0;
        end
        if (ring_shift)
        begin
            step_next = step_reg + 1'b1;
        end
        if (state_reg == ST_DRAIN && adv)
        begin
            drain_next = drain_reg + 1'b1;
        end
    end

    // pending pair and output word; the pending pair learns it is last at flush
    always_comb
    begin
        out_valid_next  = out_valid_reg && !pair_ready;
        out_word_next   = out_word_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        hits_next       = hits_reg;
        if (accept_live)
        begin
            hits_next = '0;
        end
        if (adv)
        begin
            if (hit.valid && hits_reg < HIT_W'(MAX_RESULTS))
            begin
                hits_next       = hits_reg + 1'b1;
                pend_valid_next = 1'b1;
                pend_id_next    = hit.id;
                if (pend_valid_reg)
                begin
                    out_valid_next          = 1'b1;
                    out_word_next.first_id  = pend_id_reg;
                    out_word_next.second_id = probe_reg.id;
                    out_word_next.last      = 1'b0;
                    out_word_next.overflow  = ovf_reg;
                end
            end
            else if (flush_go && pend_valid_reg)
            begin
                pend_valid_next         = 1'b0;
                out_valid_next          = 1'b1;
                out_word_next.first_id  = pend_id_reg;
                out_word_next.second_id = probe_reg.id;
                out_word_next.last      = 1'b1;
                out_word_next.overflow  = ovf_reg;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            step_reg       <= '0;
            drain_reg      <= '0;
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            hits_reg       <= '0;
            store_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            drain_reg      <= drain_next;
            count_reg      <= count_next;
            ovf_reg        <= ovf_next;
            hits_reg       <= hits_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (accept_live)
            begin
                store_reg <= !full;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept_live)
        begin
            probe_reg <= fresh;
            lim_reg   <= count_reg;
        end
        pend_id_reg  <= pend_id_next;
        out_word_reg <= out_word_next;
    end

    cpod_ring #(
        .N (MAX_ENTITIES)
    ) u_ring (
        .clk   (clk),
        .shift (ring_shift),
        .ins   (ins),
        .fresh (probe_reg),
        .head  (head)
    );

    cpod_cmp u_cmp (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .cand  (cand),
        .probe (probe_reg),
        .hit   (hit)
    );

    assign pair_valid = out_valid_reg;
    assign pair_word  = out_word_reg;

endmodule
